>>> hdl/ifc_pkg.sv
`default_nettype none

package ifc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CMD_W     = 5;
	localparam int unsigned ID_W      = 11;
	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned STATUS_W  = 3;

	localparam logic [BYTE_W-1:0]  MAX_PAYLOAD    = 8'd64;
	localparam logic [BYTE_W-1:0]  ID_HIGH_MASK   = 8'hE0;
	localparam logic [BYTE_W-1:0]  CMD_MASK       = 8'h1F;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'd511;
	localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 9'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_WRONG_ID  = 3'd3,
		ST_CSUM_ERR  = 3'd4
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              last_byte;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CMD_W-1:0]    command;
		logic [ID_W-1:0]     source_id;
		logic [BYTE_W-1:0]   payload_length;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0] station_id;
	} cfg_word_t;

endpackage

`default_nettype wire

>>> hdl/ifc_channels.sv
`default_nettype none

interface ifc_in_if;
	logic             valid;
	logic             ready;
	ifc_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ifc_out_if;
	logic              valid;
	logic              ready;
	ifc_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ifc_cfg_if;
	logic              valid;
	logic              ready;
	ifc_pkg::cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/inbound_frame_checker.sv
// Inbound frame checker: validates deframed packets carrying an XOR checksum.
//
// rx  : one packet byte per word, last_byte marks the checksum byte.
// res : one verdict word per packet (status, command, source_id,
//       payload_length), issued only for words with last_byte set.
// cfg : write channel for station_id; always ready, write only while idle.
//
// Timing: a last byte accepted into the input stage has its verdict loaded
// into the result register, which then drives res.valid high until taken.
// Throughput is one byte per cycle while rx.ready stays high; header capture,
// the running XOR and the byte counter all update in the single pass behind
// the input register.
//
// Stall: if res is not taken, the verdict holds in the result register.
// Non-last bytes keep flowing; only a second last byte waits in the input
// stage, and rx.ready drops until the result register frees up.
//
// Reset (arst_n low): packet state and station_id clear to zero, both stages
// empty. No clearing pass is needed.
`default_nettype none

module inbound_frame_checker #(
	parameter logic [ifc_pkg::BYTE_W-1:0] MAX_PAYLOAD_LEN = ifc_pkg::MAX_PAYLOAD
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ifc_in_if.sink     rx,
	ifc_out_if.source  res,
	ifc_cfg_if.sink    cfg
);
	import ifc_pkg::*;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// packet state
	logic [COUNT_W-1:0] byte_count_q;
	logic [BYTE_W-1:0]  running_xor_q;
	logic [BYTE_W-1:0]  hdr_first_q;
	logic [BYTE_W-1:0]  hdr_second_q;
	logic [BYTE_W-1:0]  hdr_length_q;
	logic [ID_W-1:0]    station_id_q;

	// result register
	logic      res_valid_q;
	out_word_t res_data_q;

	logic               advance;
	logic               verdict_load;
	logic [COUNT_W-1:0] total;
	logic [COUNT_W-1:0] expect_total;
	logic [ID_W-1:0]    src_id;
	logic [CMD_W-1:0]   cmd;
	status_t            status;
	out_word_t          verdict;

	// The input stage moves on unless it holds a last byte that has no room.
	assign advance      = !valid_s1 || !last_s1 || !res_valid_q || res.ready;
	assign verdict_load = valid_s1 && last_s1 && advance;

	assign rx.ready  = advance;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// Verdict for the byte in the input stage, valid when it is the last one.
	always_comb begin
		total        = (byte_count_q == COUNT_MAX) ? COUNT_MAX : byte_count_q + 9'd1;
		expect_total = {1'b0, hdr_length_q} + FRAME_OVERHEAD;
		cmd          = CMD_W'(hdr_second_q & CMD_MASK);
		src_id       = {hdr_first_q, 3'((hdr_second_q & ID_HIGH_MASK) >> 5)};
		priority if (total < FRAME_OVERHEAD)     status = ST_MALFORMED;
		else if (total != expect_total)          status = ST_MALFORMED;
		else if (hdr_length_q > MAX_PAYLOAD_LEN) status = ST_TOO_LONG;
		else if (src_id != station_id_q)         status = ST_WRONG_ID;
		else if (running_xor_q != byte_s1)       status = ST_CSUM_ERR;
		else                                     status = ST_OK;
		verdict.status = status;
		// A short packet reports no header fields.
		if (total < FRAME_OVERHEAD) begin
			verdict.command        = '0;
			verdict.source_id      = '0;
			verdict.payload_length = '0;
		end else begin
			verdict.command        = cmd;
			verdict.source_id      = src_id;
			verdict.payload_length = hdr_length_q;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && advance) begin
			byte_s1 <= rx.data.rx_byte;
			last_s1 <= rx.data.last_byte;
		end
	end

	// Packet state: capture header, fold XOR, count; clear after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_xor_q <= '0;
			hdr_first_q   <= '0;
			hdr_second_q  <= '0;
			hdr_length_q  <= '0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				byte_count_q  <= '0;
				running_xor_q <= '0;
				hdr_first_q   <= '0;
				hdr_second_q  <= '0;
				hdr_length_q  <= '0;
			end else begin
				if (byte_count_q == 9'd0) hdr_first_q  <= byte_s1;
				if (byte_count_q == 9'd1) hdr_second_q <= byte_s1;
				if (byte_count_q == 9'd2) hdr_length_q <= byte_s1;
				running_xor_q <= running_xor_q ^ byte_s1;
				if (byte_count_q != COUNT_MAX) byte_count_q <= byte_count_q + 9'd1;
			end
		end
	end

	// Station id register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q <= '0;
		end else if (cfg.valid) begin
			station_id_q <= cfg.data.station_id;
		end
	end

	// Result register: load a verdict, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (verdict_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_load) begin
			res_data_q <= verdict;
		end
	end

	// A processed last byte always produces a verdict next cycle.
	a_verdict_issued: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_load |=> res_valid_q)
		else $error("last byte did not produce a verdict");

	// Packet state is clean after every last byte.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_load |=> (byte_count_q == 9'd0 && running_xor_q == 8'd0))
		else $error("packet state not cleared after last byte");

	// Backpressure on rx only comes from a waiting last byte.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && last_s1 && res_valid_q))
		else $error("rx stalled without a pending verdict");

	// An accepted packet carries this station's id.
	a_ok_matches_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_data_q.status == ST_OK) |-> (res_data_q.source_id == station_id_q))
		else $error("ok verdict with foreign id");

endmodule

`default_nettype wire
